>>> rtl/pob_pkg.sv
// Shared types and constants for the polar occupancy background block.
// No dependencies; the other files, except pob_ram, refer to it by scoped names.
package pob_pkg;

    // Item modes
    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_UPDATED = 3'd0;
    localparam logic [2:0] STAT_ERASED  = 3'd1;
    localparam logic [2:0] STAT_SKIPPED = 3'd2;
    localparam logic [2:0] STAT_QUERY   = 3'd3;
    localparam logic [2:0] STAT_CLEARED = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FRAMES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX     = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_LEARNING_RATE = 16'd3277;
    localparam logic [15:0] RST_DECAY_RATE    = 16'd62259;
    localparam logic [15:0] RST_THRESHOLD     = 16'd45875;
    localparam logic [31:0] RST_DECAY_FRAMES  = 32'd100;
    localparam logic [17:0] RST_ANGLE_START   = 18'd0;
    localparam logic [15:0] RST_ANGLE_STEP    = 16'd256;
    localparam logic [15:0] RST_RANGE_MIN     = 16'd0;
    localparam logic [15:0] RST_RANGE_MAX     = 16'd12799;

    // Score arithmetic, Q0.16
    localparam logic [15:0] SCORE_ONE   = 16'hFFFF;
    localparam logic [15:0] ERASE_LIMIT = 16'd656;

    // Table entry: {present, last frame, score}
    localparam int ENTRY_W = 49;

    typedef struct packed {
        logic load_item;  // latch the input beat
        logic clr_start;  // rewind the sweep counter
        logic clr_step;   // write one cleared entry, advance
        logic rd_en;      // read the bin entry
        logic finish;     // write back the bin and load the result
    } pob_cmd_t;

    typedef struct packed {
        logic item_clear; // latched item is a clear request
        logic clr_done;   // sweep counter at last entry
    } pob_stat_t;

endpackage

>>> rtl/pob_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pob_ctrl.sv
// Sequencer for the occupancy block: reset sweep, per-item step count,
// clear sweeps and the output register handshake. Uses pob_pkg.
module pob_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output pob_pkg::pob_cmd_t  cmd,
    input  pob_pkg::pob_stat_t stat
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_WORK     = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    // WORK_RD: bin address ready, table read issued; WORK_LAST: last work step
    localparam logic [3:0] WORK_RD   = 4'd5;
    localparam logic [3:0] WORK_LAST = 4'd8;

    logic [2:0] state_reg, state_next;
    logic [3:0] wcnt_reg, wcnt_next;
    logic       from_item_reg, from_item_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        wcnt_next      = wcnt_reg;
        from_item_next = from_item_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = from_item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                wcnt_next      = '0;
                from_item_next = stat.item_clear;
                if (stat.item_clear)
                begin
                    cmd.clr_start = 1'b1;
                    state_next    = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                wcnt_next  = wcnt_reg + 4'd1;
                cmd.rd_en  = (wcnt_reg == WORK_RD);
                if (wcnt_reg == WORK_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wcnt_reg      <= '0;
            from_item_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wcnt_reg      <= wcnt_next;
            from_item_reg <= from_item_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/pob_datapath.sv
// Datapath: config registers, beam-to-bin mapping pipeline, bin table,
// score decay and moving-average update. Uses pob_pkg and pob_ram.
module pob_datapath #(
    parameter int ANGLE_BINS    = 500,
    parameter int RANGE_BINS    = 128,
    parameter int RANGE_STEP_MM = 100
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pob_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pob_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]                      mode,
    input  logic [11:0]                     beam_index,
    input  logic [15:0]                     range_mm,
    input  logic                            range_valid,
    input  logic [31:0]                     frame,
    output logic [2:0]                      status,
    output logic                            is_background,
    output logic [15:0]                     score,
    input  pob_pkg::pob_cmd_t               cmd,
    output pob_pkg::pob_stat_t              stat
);

    localparam int DEPTH  = ANGLE_BINS * RANGE_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int AB_W   = $clog2(ANGLE_BINS);
    localparam int RB_W   = $clog2(RANGE_BINS);
    localparam int MUL_W  = AB_W + 13;
    // multiple of ANGLE_BINS that lifts the most negative coarse angle to >= 0
    localparam int ANG_OFS = ANGLE_BINS * ((512 + ANGLE_BINS - 1) / ANGLE_BINS);
    localparam int A_RECIP = (1 << 21) / ANGLE_BINS;
    localparam int R_RECIP = (1 << 16) / RANGE_STEP_MM;
    localparam logic [12:0] A_C  = 13'(ANGLE_BINS);
    localparam logic [12:0] RB_C = 13'(RANGE_BINS);
    localparam logic [13:0] RS_C = 14'(RANGE_STEP_MM);

    // ---------------- configuration ----------------
    logic [15:0]        lr_reg, dr_reg, thr_reg, step_reg, rmin_reg, rmax_reg;
    logic [31:0]        df_reg;
    logic signed [17:0] as_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= pob_pkg::RST_LEARNING_RATE;
            dr_reg   <= pob_pkg::RST_DECAY_RATE;
            thr_reg  <= pob_pkg::RST_THRESHOLD;
            df_reg   <= pob_pkg::RST_DECAY_FRAMES;
            as_reg   <= pob_pkg::RST_ANGLE_START;
            step_reg <= pob_pkg::RST_ANGLE_STEP;
            rmin_reg <= pob_pkg::RST_RANGE_MIN;
            rmax_reg <= pob_pkg::RST_RANGE_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pob_pkg::REG_LEARNING_RATE: lr_reg   <= cfg_data[15:0];
                pob_pkg::REG_DECAY_RATE:    dr_reg   <= cfg_data[15:0];
                pob_pkg::REG_THRESHOLD:     thr_reg  <= cfg_data[15:0];
                pob_pkg::REG_DECAY_FRAMES:  df_reg   <= cfg_data;
                pob_pkg::REG_ANGLE_START:   as_reg   <= cfg_data[17:0];
                pob_pkg::REG_ANGLE_STEP:    step_reg <= cfg_data[15:0];
                pob_pkg::REG_RANGE_MIN:     rmin_reg <= cfg_data[15:0];
                pob_pkg::REG_RANGE_MAX:     rmax_reg <= cfg_data[15:0];
                default:                    ;
            endcase
        end
    end

    // ---------------- item latch ----------------
    logic [1:0]  it_mode_reg;
    logic [11:0] it_beam_reg;
    logic [15:0] it_range_reg;
    logic        it_valid_reg;
    logic [31:0] it_frame_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            it_mode_reg  <= mode;
            it_beam_reg  <= beam_index;
            it_range_reg <= range_mm;
            it_valid_reg <= range_valid;
            it_frame_reg <= frame;
        end
    end

    // ---------------- bin mapping ----------------
    // The item is held for the whole step, so every stage settles in turn.
    logic signed [29:0] ang_reg, ang_next;
    logic [32:0]        rprod_reg, rprod_next;
    logic               win_ok_reg, win_ok_next;
    logic [20:0]        u_reg, u_next;
    logic [15:0]        rmul_reg, rmul_next;
    logic [41:0]        aprod_reg, aprod_next;
    logic [15:0]        rbin_reg, rbin_next;
    logic [21:0]        qa_reg, qa_next;
    logic               in_tab_reg, in_tab_next;
    logic [AB_W-1:0]    abin_reg, abin_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;

    logic [27:0]        bprod;
    logic [21:0]        ahi_ofs;
    logic [29:0]        rmul_full;
    logic [15:0]        rrem;
    logic [33:0]        qa_full;
    logic [21:0]        arem;
    logic [MUL_W-1:0]   amul;

    always_comb
    begin
        bprod    = it_beam_reg * step_reg;
        ang_next = $signed({{12{as_reg[17]}}, as_reg}) + $signed({2'b00, bprod});
        rprod_next  = it_range_reg * 17'(R_RECIP);
        win_ok_next = it_valid_reg && (it_range_reg >= rmin_reg) &&
                      (it_range_reg <= rmax_reg);

        // coarse angle = floor(angle / 256); negative values lifted by a multiple
        ahi_ofs   = ang_reg[29:8] + 22'(ANG_OFS);
        u_next    = ang_reg[29] ? ahi_ofs[20:0] : ang_reg[28:8];
        rmul_full = rprod_reg[31:16] * RS_C;
        rmul_next = rmul_full[15:0];

        aprod_next = u_reg * 21'(A_RECIP);
        rrem       = it_range_reg - rmul_reg;
        rbin_next  = rprod_reg[31:16] + {15'd0, (rrem >= 16'(RANGE_STEP_MM))};

        qa_full     = aprod_reg[41:21] * A_C;
        qa_next     = qa_full[21:0];
        in_tab_next = (rbin_reg < 16'(RANGE_BINS));

        // quotient estimate is exact or one low
        arem      = {1'b0, u_reg} - qa_reg;
        abin_next = (arem >= 22'(ANGLE_BINS)) ? AB_W'(arem - 22'(ANGLE_BINS))
                                              : AB_W'(arem);

        amul      = abin_reg * RB_C;
        addr_next = ADDR_W'(amul + MUL_W'(rbin_reg[RB_W-1:0]));
    end

    always_ff @(posedge clk)
    begin
        ang_reg    <= ang_next;
        rprod_reg  <= rprod_next;
        win_ok_reg <= win_ok_next;
        u_reg      <= u_next;
        rmul_reg   <= rmul_next;
        aprod_reg  <= aprod_next;
        rbin_reg   <= rbin_next;
        qa_reg     <= qa_next;
        in_tab_reg <= in_tab_next;
        abin_reg   <= abin_next;
        addr_reg   <= addr_next;
    end

    // ---------------- bin table ----------------
    logic [ADDR_W-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [pob_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic                        upd_hit;
    logic                        erase_reg, erase_next;
    logic [15:0]                 new_score;

    always_comb
    begin
        if (cmd.clr_start)
        begin
            clr_cnt_next = '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end
        else
        begin
            clr_cnt_next = clr_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign stat.clr_done   = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign stat.item_clear = (it_mode_reg == pob_pkg::MODE_CLEAR);

    assign upd_hit = (it_mode_reg == pob_pkg::MODE_UPDATE) && win_ok_reg && in_tab_reg;

    always_comb
    begin
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.finish && upd_hit;
            ram_waddr = addr_reg;
            ram_wdata = {~erase_reg, it_frame_reg, new_score};
        end
    end

    pob_ram #(
        .WIDTH (pob_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // ---------------- score update ----------------
    logic        pres_reg, pres_next;
    logic [15:0] s0_reg, s0_next;
    logic        stale_reg, stale_next;
    logic [31:0] dprod_reg, dprod_next;
    logic [15:0] seff_reg, seff_next;
    logic [32:0] uprod_reg, uprod_next;
    logic [31:0] last0;
    logic [31:0] gap;
    logic [15:0] dscore;
    logic [16:0] lr_comp;
    logic [17:0] nsum;

    always_comb
    begin
        pres_next  = ram_rdata[48] && in_tab_reg;
        s0_next    = pres_next ? ram_rdata[15:0] : 16'd0;
        last0      = pres_next ? ram_rdata[47:16] : 32'd0;
        gap        = it_frame_reg - last0;
        stale_next = (last0 != 32'd0) && (gap > df_reg);
        dprod_next = s0_next * dr_reg;

        dscore     = dprod_reg[31:16];
        erase_next = stale_reg && (dscore < pob_pkg::ERASE_LIMIT);
        seff_next  = stale_reg ? dscore : s0_reg;

        lr_comp    = 17'h10000 - {1'b0, lr_reg};
        uprod_next = lr_comp * seff_reg;

        nsum      = {2'b00, lr_reg} + {1'b0, uprod_reg[32:16]};
        new_score = (nsum > 18'({2'b00, pob_pkg::SCORE_ONE})) ? pob_pkg::SCORE_ONE
                                                              : nsum[15:0];
    end

    always_ff @(posedge clk)
    begin
        pres_reg  <= pres_next;
        s0_reg    <= s0_next;
        stale_reg <= stale_next;
        dprod_reg <= dprod_next;
        erase_reg <= erase_next;
        seff_reg  <= seff_next;
        uprod_reg <= uprod_next;
    end

    // ---------------- result register ----------------
    logic [2:0]  res_status;
    logic        res_bg;
    logic [15:0] res_score;
    logic [2:0]  status_reg;
    logic        bg_reg;
    logic [15:0] score_reg;

    always_comb
    begin
        res_status = pob_pkg::STAT_SKIPPED;
        res_bg     = 1'b0;
        res_score  = 16'd0;
        case (it_mode_reg)
            pob_pkg::MODE_UPDATE:
            begin
                if (upd_hit)
                begin
                    if (erase_reg)
                    begin
                        res_status = pob_pkg::STAT_ERASED;
                    end
                    else
                    begin
                        res_status = pob_pkg::STAT_UPDATED;
                        res_score  = new_score;
                    end
                end
            end
            pob_pkg::MODE_QUERY:
            begin
                res_status = pob_pkg::STAT_QUERY;
                res_score  = s0_reg;
                res_bg     = pres_reg && (s0_reg > thr_reg);
            end
            pob_pkg::MODE_CLEAR:
            begin
                res_status = pob_pkg::STAT_CLEARED;
            end
            default:
            begin
                res_status = pob_pkg::STAT_SKIPPED;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= res_status;
            bg_reg     <= res_bg;
            score_reg  <= res_score;
        end
    end

    assign status        = status_reg;
    assign is_background = bg_reg;
    assign score         = score_reg;

endmodule

>>> rtl/polar_occupancy_background.sv
// Polar occupancy background: one result beat per input beat.
// Update and query: the beat passes the mapping multipliers and the table
// read-modify-write; a new beat is taken only once the last result is loaded.
// Clear: a sweep over ANGLE_BINS*RANGE_BINS entries, one table entry written per cycle.
// Reset: async active low; a sweep over all ANGLE_BINS*RANGE_BINS entries clears the
// table before in_ready rises. Uses pob_pkg, pob_ctrl, pob_datapath.
module polar_occupancy_background #(
    parameter int ANGLE_BINS    = 500,
    parameter int RANGE_BINS    = 128,
    parameter int RANGE_STEP_MM = 100
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pob_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pob_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      mode,
    input  logic [11:0]                     beam_index,
    input  logic [15:0]                     range_mm,
    input  logic                            range_valid,
    input  logic [31:0]                     frame,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      status,
    output logic                            is_background,
    output logic [15:0]                     score
);

    pob_pkg::pob_cmd_t  cmd;
    pob_pkg::pob_stat_t stat;

    pob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pob_datapath #(
        .ANGLE_BINS    (ANGLE_BINS),
        .RANGE_BINS    (RANGE_BINS),
        .RANGE_STEP_MM (RANGE_STEP_MM)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .beam_index    (beam_index),
        .range_mm      (range_mm),
        .range_valid   (range_valid),
        .frame         (frame),
        .status        (status),
        .is_background (is_background),
        .score         (score),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

>>> bench/tb.sv
// Testbench for polar_occupancy_background: directed table, then random phases.
// Predicts each result beat from a shadow bin table and register copy.
// Depends on rtl/pob_pkg.sv and rtl/polar_occupancy_background.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BINS    = 500;
    localparam int RANGE_BINS    = 128;
    localparam int RANGE_STEP_MM = 100;
    localparam int BIN_COUNT     = ANGLE_BINS * RANGE_BINS;
    localparam int MAX_GAP       = 17;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 250;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] beam;
        logic [15:0] rng;
        logic        usable;
        logic [31:0] frm;
    } beam_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        background;
        logic [15:0] score;
    } verdict_t;

    typedef struct packed {
        bit                            is_reg;
        logic [pob_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [31:0]                   reg_val;
        beam_t                         beat;
        bit                            known;
        verdict_t                      want;
    } plan_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [pob_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pob_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [1:0]                     mode = '0;
    logic [11:0]                    beam_index = '0;
    logic [15:0]                    range_mm = '0;
    logic                           range_valid = 1'b0;
    logic [31:0]                    frame = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [2:0]                     status;
    logic                           is_background;
    logic [15:0]                    score;

    // shadow registers
    logic [15:0] learn_w    = pob_pkg::RST_LEARNING_RATE;
    logic [15:0] decay_w    = pob_pkg::RST_DECAY_RATE;
    logic [15:0] thresh_w   = pob_pkg::RST_THRESHOLD;
    logic [31:0] stale_gap  = pob_pkg::RST_DECAY_FRAMES;
    int          ang_origin = 0;
    logic [15:0] ang_pitch  = pob_pkg::RST_ANGLE_STEP;
    logic [15:0] near_mm    = pob_pkg::RST_RANGE_MIN;
    logic [15:0] far_mm     = pob_pkg::RST_RANGE_MAX;

    // shadow bin table
    bit [15:0] bin_score   [BIN_COUNT];
    bit [31:0] bin_frame   [BIN_COUNT];
    bit        bin_present [BIN_COUNT];

    verdict_t    due_verdicts[$];
    plan_row_t   plan[$];
    int          errors = 0;
    bit          no_gaps = 1'b0;
    logic [31:0] frame_clock = 32'd1;
    int          clears_left = 4;

    polar_occupancy_background #(
        .ANGLE_BINS    (ANGLE_BINS),
        .RANGE_BINS    (RANGE_BINS),
        .RANGE_STEP_MM (RANGE_STEP_MM)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .beam_index    (beam_index),
        .range_mm      (range_mm),
        .range_valid   (range_valid),
        .frame         (frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .is_background (is_background),
        .score         (score)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("FAIL polar_occupancy_background");
        $finish;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // angle wraps into [0, 256*ANGLE_BINS); range bins past the table miss
    function automatic bit bin_lookup(input logic [11:0] beam, input logic [15:0] rng,
                                      output int addr);
        longint full;
        longint ang;
        longint red;
        int     abin;
        int     rbin;
        full = longint'(ANGLE_BINS) * 256;
        ang  = longint'(ang_origin) + longint'(beam) * longint'(ang_pitch);
        red  = ang % full;
        if (red < 0)
            red += full;
        abin = int'(red / 256);
        rbin = int'(rng) / RANGE_STEP_MM;
        addr = 0;
        if (abin >= ANGLE_BINS || rbin >= RANGE_BINS)
            return 1'b0;
        addr = abin * RANGE_BINS + rbin;
        return 1'b1;
    endfunction

    function automatic verdict_t predict_verdict(input beam_t b);
        verdict_t    v;
        int          addr;
        bit          hit;
        logic [31:0] s;
        logic [31:0] last;
        logic [31:0] gap;
        logic [63:0] n;
        v.status     = pob_pkg::STAT_SKIPPED;
        v.background = 1'b0;
        v.score      = '0;
        hit = bin_lookup(b.beam, b.rng, addr);
        case (b.op)
            pob_pkg::MODE_UPDATE:
            begin
                if (b.usable && b.rng >= near_mm && b.rng <= far_mm && hit)
                begin
                    s    = bin_present[addr] ? 32'(bin_score[addr]) : 32'd0;
                    last = bin_present[addr] ? bin_frame[addr] : 32'd0;
                    gap  = b.frm - last;
                    if (last != 32'd0 && gap > stale_gap)
                    begin
                        s = 32'((64'(s) * 64'(decay_w)) >> 16);
                        if (s < 32'(pob_pkg::ERASE_LIMIT))
                        begin
                            bin_present[addr] = 1'b0;
                            v.status = pob_pkg::STAT_ERASED;
                            return v;
                        end
                    end
                    n = 64'(learn_w) + (((64'd65536 - 64'(learn_w)) * 64'(s)) >> 16);
                    if (n > 64'(pob_pkg::SCORE_ONE))
                        n = 64'(pob_pkg::SCORE_ONE);
                    bin_score[addr]   = n[15:0];
                    bin_frame[addr]   = b.frm;
                    bin_present[addr] = 1'b1;
                    v.status = pob_pkg::STAT_UPDATED;
                    v.score  = n[15:0];
                end
            end
            pob_pkg::MODE_QUERY:
            begin
                v.status = pob_pkg::STAT_QUERY;
                if (hit && bin_present[addr])
                begin
                    v.score      = bin_score[addr];
                    v.background = (bin_score[addr] > thresh_w);
                end
            end
            pob_pkg::MODE_CLEAR:
            begin
                for (int i = 0; i < BIN_COUNT; i++)
                    bin_present[i] = 1'b0;
                v.status = pob_pkg::STAT_CLEARED;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic plan_row_t beat_row(input logic [1:0] op, input logic [11:0] beam,
                                           input logic [15:0] rng, input logic usable,
                                           input logic [31:0] frm);
        plan_row_t r;
        r = '0;
        r.beat.op     = op;
        r.beat.beam   = beam;
        r.beat.rng    = rng;
        r.beat.usable = usable;
        r.beat.frm    = frm;
        return r;
    endfunction

    // rows whose answer is plain: background bit is zero in all of them
    function automatic plan_row_t known_row(input logic [1:0] op, input logic [11:0] beam,
                                            input logic [15:0] rng, input logic usable,
                                            input logic [31:0] frm, input logic [2:0] st,
                                            input logic [15:0] sc);
        plan_row_t r;
        r = beat_row(op, beam, rng, usable, frm);
        r.known       = 1'b1;
        r.want.status = st;
        r.want.score  = sc;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [pob_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
        plan_row_t r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // mostly a handful of bins with slowly advancing frames, so bins age and erase
    function automatic beam_t random_beam();
        beam_t b;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 68)
            b.op = pob_pkg::MODE_UPDATE;
        else if (pick < 92)
            b.op = pob_pkg::MODE_QUERY;
        else if (pick < 95)
            b.op = MODE_UNUSED;
        else if (clears_left > 0 && $urandom_range(0, 19) == 0)
        begin
            b.op = pob_pkg::MODE_CLEAR;
            clears_left--;
        end
        else
            b.op = pob_pkg::MODE_UPDATE;
        b.beam = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 5));
        b.rng  = ($urandom_range(0, 4) == 0) ? 16'($urandom)
               : 16'($urandom_range(0, 3) * 100 + $urandom_range(0, 99));
        b.usable = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 19))
            0:       frame_clock += 32'($urandom_range(100, 400));
            1:       frame_clock = $urandom;
            default: frame_clock += 32'($urandom_range(0, 2));
        endcase
        b.frm = ($urandom_range(0, 29) == 0) ? 32'd0 : frame_clock;
        return b;
    endfunction

    // registers change only with the block idle: sender paused, all results in
    task automatic write_reg(input logic [pob_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        in_valid <= 1'b0;
        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pob_pkg::REG_LEARNING_RATE: learn_w    = val[15:0];
            pob_pkg::REG_DECAY_RATE:    decay_w    = val[15:0];
            pob_pkg::REG_THRESHOLD:     thresh_w   = val[15:0];
            pob_pkg::REG_DECAY_FRAMES:  stale_gap  = val;
            pob_pkg::REG_ANGLE_START:   ang_origin = $signed(val[17:0]);
            pob_pkg::REG_ANGLE_STEP:    ang_pitch  = val[15:0];
            pob_pkg::REG_RANGE_MIN:     near_mm    = val[15:0];
            pob_pkg::REG_RANGE_MAX:     far_mm     = val[15:0];
            default: ;
        endcase
    endtask

    task automatic send_beam(input beam_t b, input bit known, input verdict_t want);
        int       gap;
        verdict_t v;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= b.op;
        beam_index  <= b.beam;
        range_mm    <= b.rng;
        range_valid <= b.usable;
        frame       <= b.frm;
        do
            @(posedge clk);
        while (!in_ready);
        v = predict_verdict(b);
        due_verdicts.push_back(known ? want : v);
    endtask

    task automatic random_setting();
        logic [31:0] dfr;
        int          astart;
        logic [15:0] rmin;
        logic [15:0] rmax;
        write_reg(pob_pkg::REG_LEARNING_RATE, 32'(pick_rate()));
        write_reg(pob_pkg::REG_DECAY_RATE, 32'(pick_rate()));
        write_reg(pob_pkg::REG_THRESHOLD, 32'(pick_rate()));
        case ($urandom_range(0, 5))
            0:       dfr = 32'd0;
            1:       dfr = 32'hFFFF_FFFF;
            default: dfr = 32'($urandom_range(1, 300));
        endcase
        write_reg(pob_pkg::REG_DECAY_FRAMES, dfr);
        case ($urandom_range(0, 3))
            0:       astart = -128000;
            1:       astart = 127999;
            default: astart = int'($urandom_range(0, 255999)) - 128000;
        endcase
        write_reg(pob_pkg::REG_ANGLE_START, 32'(astart));
        write_reg(pob_pkg::REG_ANGLE_STEP, 32'(pick_rate()));
        rmin = 16'($urandom_range(0, 150));
        rmax = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(300, 12799));
        if ($urandom_range(0, 7) == 0)
        begin
            rmin = 16'd1000;
            rmax = 16'd500;
        end
        write_reg(pob_pkg::REG_RANGE_MIN, 32'(rmin));
        write_reg(pob_pkg::REG_RANGE_MAX, 32'(rmax));
    endtask

    initial
    begin
        plan.push_back(known_row(pob_pkg::MODE_QUERY, 0, 0, 1, 0,
                                 pob_pkg::STAT_QUERY, 0));
        plan.push_back(known_row(pob_pkg::MODE_UPDATE, 0, 0, 1, 1,
                                 pob_pkg::STAT_UPDATED, pob_pkg::RST_LEARNING_RATE));
        plan.push_back(beat_row(pob_pkg::MODE_UPDATE, 0, 99, 1, 2));
        plan.push_back(beat_row(pob_pkg::MODE_QUERY, 0, 50, 0, 0));
        plan.push_back(known_row(pob_pkg::MODE_UPDATE, 7, 300, 0, 3,
                                 pob_pkg::STAT_SKIPPED, 0));
        plan.push_back(known_row(pob_pkg::MODE_UPDATE, 7, 12800, 1, 3,
                                 pob_pkg::STAT_SKIPPED, 0));
        plan.push_back(known_row(pob_pkg::MODE_QUERY, 0, 16'hFFFF, 1, 3,
                                 pob_pkg::STAT_QUERY, 0));
        plan.push_back(known_row(pob_pkg::MODE_QUERY, 12'hFFF, 12799, 0, 32'hFFFF_FFFF,
                                 pob_pkg::STAT_QUERY, 0));
        plan.push_back(known_row(MODE_UNUSED, 12'hFFF, 16'hFFFF, 1, 32'hFFFF_FFFF,
                                 pob_pkg::STAT_SKIPPED, 0));
        // stale bin, then a frame counter that wraps, then a zero frame
        plan.push_back(beat_row(pob_pkg::MODE_UPDATE, 0, 0, 1, 200));
        plan.push_back(beat_row(pob_pkg::MODE_UPDATE, 0, 0, 1, 32'hFFFF_FFF0));
        plan.push_back(beat_row(pob_pkg::MODE_UPDATE, 0, 0, 1, 5));
        plan.push_back(beat_row(pob_pkg::MODE_UPDATE, 0, 0, 1, 0));
        plan.push_back(beat_row(pob_pkg::MODE_UPDATE, 0, 0, 1, 5000));
        plan.push_back(reg_row(pob_pkg::REG_LEARNING_RATE, 32'hFFFF));
        plan.push_back(reg_row(pob_pkg::REG_DECAY_RATE, 0));
        plan.push_back(reg_row(pob_pkg::REG_DECAY_FRAMES, 0));
        plan.push_back(beat_row(pob_pkg::MODE_UPDATE, 1, 100, 1, 10));
        plan.push_back(known_row(pob_pkg::MODE_UPDATE, 1, 100, 1, 11,
                                 pob_pkg::STAT_ERASED, 0));
        plan.push_back(known_row(pob_pkg::MODE_QUERY, 1, 100, 1, 11,
                                 pob_pkg::STAT_QUERY, 0));
        plan.push_back(reg_row(pob_pkg::REG_LEARNING_RATE, 0));
        plan.push_back(reg_row(pob_pkg::REG_THRESHOLD, 0));
        plan.push_back(beat_row(pob_pkg::MODE_UPDATE, 2, 0, 1, 1));
        plan.push_back(beat_row(pob_pkg::MODE_QUERY, 0, 0, 1, 0));
        plan.push_back(reg_row(pob_pkg::REG_THRESHOLD, 32'hFFFF));
        plan.push_back(reg_row(pob_pkg::REG_DECAY_FRAMES, 32'hFFFF_FFFF));
        plan.push_back(reg_row(pob_pkg::REG_ANGLE_START, 32'(-128000)));
        plan.push_back(reg_row(pob_pkg::REG_ANGLE_STEP, 32'hFFFF));
        plan.push_back(beat_row(pob_pkg::MODE_UPDATE, 12'hFFF, 12799, 1, 7));
        plan.push_back(beat_row(pob_pkg::MODE_QUERY, 12'hFFF, 12799, 0, 7));
        plan.push_back(reg_row(pob_pkg::REG_ANGLE_START, 32'd127999));
        plan.push_back(reg_row(pob_pkg::REG_RANGE_MIN, 32'hFFFF));
        plan.push_back(reg_row(pob_pkg::REG_RANGE_MAX, 32'hFFFF));
        // inside the window but past the last range bin
        plan.push_back(known_row(pob_pkg::MODE_UPDATE, 3, 16'hFFFF, 1, 8,
                                 pob_pkg::STAT_SKIPPED, 0));
        plan.push_back(reg_row(pob_pkg::REG_RANGE_MIN, 500));
        plan.push_back(reg_row(pob_pkg::REG_RANGE_MAX, 400));
        plan.push_back(known_row(pob_pkg::MODE_UPDATE, 0, 450, 1, 9,
                                 pob_pkg::STAT_SKIPPED, 0));
        plan.push_back(known_row(pob_pkg::MODE_CLEAR, 0, 0, 0, 0,
                                 pob_pkg::STAT_CLEARED, 0));
        plan.push_back(known_row(pob_pkg::MODE_QUERY, 0, 0, 1, 9,
                                 pob_pkg::STAT_QUERY, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_beam(plan[i].beat, plan[i].known, plan[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_setting();
            no_gaps = (ph == 3);
            repeat (PHASE_BEATS) send_beam(random_beam(), 1'b0, '0);
        end
        no_gaps = 1'b0;
        in_valid <= 1'b0;

        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS polar_occupancy_background");
        else
            $display("FAIL polar_occupancy_background");
        $finish;
    end

    // result side: random stall before each beat, compare against oldest prediction
    initial
    begin
        int       stall;
        verdict_t got;
        verdict_t want;
        bit       bad;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got.status     = status;
            got.background = is_background;
            got.score      = score;
            if (due_verdicts.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: status %0d bg %0d score %0d",
                         $time, got.status, got.background, got.score);
                errors++;
            end
            else
            begin
                want = due_verdicts.pop_front();
                bad  = 1'b0;
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    bad = 1'b1;
                end
                if (got.background !== want.background)
                begin
                    $display("%0t: is_background expected %0d actual %0d",
                             $time, want.background, got.background);
                    bad = 1'b1;
                end
                if (got.score !== want.score)
                begin
                    $display("%0t: score expected %0d actual %0d",
                             $time, want.score, got.score);
                    bad = 1'b1;
                end
                if (bad)
                    errors++;
            end
        end
    end

endmodule
